// ===== sv/upd_pkg.sv =====
// upd_pkg: shared types, character codes and the hex digit helper
// used by the url percent decoder modules; no dependencies
package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [3:0] DigitBaseAlpha = 4'd10;

  typedef enum logic [2:0] {
    PH_NORMAL,
    PH_HEX1,
    PH_HEX2,
    PH_SKIP,
    PH_FAILED
  } phase_t;

  typedef enum logic [1:0] {
    OC_CONT,
    OC_OK,
    OC_FAIL
  } outcome_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    outcome_t   outcome;
    logic       string_end;
  } res_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] val;
  } nibble_t;

  function automatic nibble_t nibble_value(input logic [7:0] c);
    nibble_t n;
    n.bad = 1'b0;
    n.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      n.val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      n.val = c[3:0] - 4'd1 + DigitBaseAlpha;
    end else begin
      n.bad = 1'b1;
    end
    return n;
  endfunction

endpackage

// ===== sv/upd_decode.sv =====
// upd_decode: per-byte decode step, next phase and high nibble from the
// current state and one registered input byte; depends on upd_pkg
module upd_decode (
  input  upd_pkg::phase_t phase,
  input  logic [3:0]      high_nibble,
  input  logic [7:0]      in_byte,
  input  logic            is_last,
  output upd_pkg::phase_t phase_next,
  output logic [3:0]      high_nibble_next,
  output upd_pkg::res_t   res_next
);
  import upd_pkg::*;

  nibble_t nib;

  always_comb begin
    nib              = nibble_value(in_byte);
    phase_next       = phase;
    high_nibble_next = high_nibble;
    res_next         = '0;
    res_next.outcome = OC_CONT;
    res_next.string_end = is_last;

    unique case (phase)
      PH_HEX1: begin
        if (nib.bad || is_last) begin
          res_next.outcome = OC_FAIL;
          phase_next       = PH_FAILED;
        end else begin
          high_nibble_next = nib.val;
          phase_next       = PH_HEX2;
        end
      end
      PH_HEX2: begin
        if (nib.bad) begin
          res_next.outcome = OC_FAIL;
          phase_next       = PH_FAILED;
        end else begin
          res_next.out_valid = 1'b1;
          res_next.out_byte  = {high_nibble, nib.val};
          phase_next         = PH_NORMAL;
        end
      end
      PH_SKIP: begin
        phase_next = PH_SKIP;
      end
      PH_FAILED: begin
        res_next.outcome = OC_FAIL;
      end
      default: begin
        phase_next = PH_NORMAL;
        priority if (in_byte == CH_PERCENT) begin
          if (is_last) begin
            res_next.outcome = OC_FAIL;
            phase_next       = PH_FAILED;
          end else begin
            phase_next = PH_HEX1;
          end
        end else if (in_byte == CH_PLUS) begin
          res_next.out_valid = 1'b1;
          res_next.out_byte  = CH_SPACE;
        end else if (in_byte == CH_HASH) begin
          phase_next = PH_SKIP;
        end else if (in_byte == CH_NUL) begin
          res_next.outcome = OC_FAIL;
          phase_next       = PH_FAILED;
        end else begin
          res_next.out_valid = 1'b1;
          res_next.out_byte  = in_byte;
        end
      end
    endcase

    if (is_last) begin
      if (res_next.outcome != OC_FAIL) begin
        res_next.outcome = OC_OK;
      end
      phase_next       = PH_NORMAL;
      high_nibble_next = 4'd0;
    end
  end

endmodule

// ===== sv/url_percent_decoder.sv =====
// url_percent_decoder: an input transfer goes to the input register, then its
// result to the output register; throughput one byte per cycle when res_stall
// does not hold the result; a single decode step lies between the input register
// and the result register; synchronous active-high reset empties both registers,
// phase to normal, high nibble to zero; depends on upd_pkg and upd_decode
module url_percent_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       is_last,
  output logic       res_valid,
  input  logic       res_stall,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic [1:0] outcome,
  output logic       string_end
);
  import upd_pkg::*;

  logic       in_full;
  logic [7:0] byte_q;
  logic       last_q;
  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] high_nibble;
  logic [3:0] high_nibble_next;
  res_t       res;
  res_t       res_next;
  logic       move;
  logic       accept;

  assign move     = in_full && (!res_valid || !res_stall);
  assign in_stall = in_full && !move;
  assign accept   = in_valid && !in_stall;

  upd_decode u_decode (
    .phase            (phase),
    .high_nibble      (high_nibble),
    .in_byte          (byte_q),
    .is_last          (last_q),
    .phase_next       (phase_next),
    .high_nibble_next (high_nibble_next),
    .res_next         (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full     <= 1'b0;
      res_valid   <= 1'b0;
      phase       <= PH_NORMAL;
      high_nibble <= 4'd0;
    end else begin
      if (accept) begin
        in_full <= 1'b1;
      end else if (move) begin
        in_full <= 1'b0;
      end
      if (move) begin
        res_valid   <= 1'b1;
        phase       <= phase_next;
        high_nibble <= high_nibble_next;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q <= in_byte;
      last_q <= is_last;
    end
    if (move) begin
      res <= res_next;
    end
  end

  assign out_valid  = res.out_valid;
  assign out_byte   = res.out_byte;
  assign outcome    = res.outcome;
  assign string_end = res.string_end;

endmodule

// ===== sv/upd_checker.sv =====
// upd_checker: port-level checks for url_percent_decoder, bound to the top
// level; depends on upd_pkg
module upd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_byte,
  input logic       is_last,
  input logic       res_valid,
  input logic       res_stall,
  input logic       out_valid,
  input logic [7:0] out_byte,
  input logic [1:0] outcome,
  input logic       string_end
);
  import upd_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(is_last))
    else $error("input transfer changed while stalled");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(out_byte) && $stable(outcome)
      && $stable(out_valid) && $stable(string_end))
    else $error("result changed while stalled");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_valid |-> out_byte == 8'd0)
    else $error("byte nonzero without out_valid");

  a_ok_at_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && (outcome == OC_OK) |-> string_end)
    else $error("clean finish before end of string");

  a_fail_no_byte: assert property (@(posedge clk) disable iff (rst)
    res_valid && (outcome == OC_FAIL) |-> !out_valid)
    else $error("byte emitted with failure");

endmodule

bind url_percent_decoder upd_checker u_upd_checker (.*);
